FILE: rtl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/tarm_pkg.sv
// Types and constants for the three-angle rotation matrix.
// No dependencies.
package tarm_pkg;
   localparam int AngleWidth = 16;
   localparam int EntryWidth = 16;
   localparam int CordicWidth = 36;
   localparam int AtanEntries = 24;
   localparam int TrigWidth = 22;
   localparam logic signed [CordicWidth-1:0] PiQ30 = 36'sd3373259426;
   localparam logic signed [CordicWidth-1:0] HalfPiQ30 = 36'sd1686629713;
   localparam logic signed [CordicWidth-1:0] InvGainQ30 = 36'sd652032874;
   localparam logic signed [EntryWidth-1:0] EntryMax = 16'sd16384;

   typedef struct packed {
      logic signed [AngleWidth-1:0] angle_01;
      logic signed [AngleWidth-1:0] angle_02;
      logic signed [AngleWidth-1:0] angle_12;
   } req_type;

   typedef struct packed {
      logic signed [EntryWidth-1:0] entry_r0_c0;
      logic signed [EntryWidth-1:0] entry_r0_c1;
      logic signed [EntryWidth-1:0] entry_r0_c2;
      logic signed [EntryWidth-1:0] entry_r1_c0;
      logic signed [EntryWidth-1:0] entry_r1_c1;
      logic signed [EntryWidth-1:0] entry_r1_c2;
      logic signed [EntryWidth-1:0] entry_r2_c0;
      logic signed [EntryWidth-1:0] entry_r2_c1;
      logic signed [EntryWidth-1:0] entry_r2_c2;
   } rsp_type;

   // one CORDIC lane state
   typedef struct packed {
      logic signed [CordicWidth-1:0] x;
      logic signed [CordicWidth-1:0] y;
      logic signed [CordicWidth-1:0] z;
      logic                          flip;
   } lane_type;

   typedef struct packed {
      lane_type [2:0] lane;
   } cell_type;

   function automatic logic signed [CordicWidth-1:0] atan_q30(input int idx);
      logic signed [CordicWidth-1:0] t;
      case (idx)
         0:  t = 36'sh03243F6A8;
         1:  t = 36'sh01DAC6705;
         2:  t = 36'sh00FADBAFC;
         3:  t = 36'sh007F56EA6;
         4:  t = 36'sh003FEAB76;
         5:  t = 36'sh001FFD55B;
         6:  t = 36'sh000FFFAAA;
         7:  t = 36'sh0007FFF55;
         8:  t = 36'sh0003FFFEA;
         9:  t = 36'sh0001FFFFD;
         10: t = 36'sh0000FFFFF;
         11: t = 36'sh00007FFFF;
         12: t = 36'sh00003FFFF;
         13: t = 36'sh00001FFFF;
         14: t = 36'sh00000FFFF;
         15: t = 36'sh000007FFF;
         16: t = 36'sh000003FFF;
         17: t = 36'sh000001FFF;
         18: t = 36'sh000000FFF;
         19: t = 36'sh0000007FF;
         20: t = 36'sh0000003FF;
         21: t = 36'sh0000001FF;
         22: t = 36'sh0000000FF;
         default: t = 36'sh00000007F;
      endcase
      return t;
   endfunction
endpackage

FILE: rtl/tarm_cell.sv
// One CORDIC micro-rotation cell, three lanes in parallel.
// Depends on tarm_pkg.
module tarm_cell #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                advance,
   input  tarm_pkg::cell_type  cell_in,
   output tarm_pkg::cell_type  cell_out
);
   import tarm_pkg::*;

   cell_type cell_ff, cell_in_d;
   localparam logic signed [CordicWidth-1:0] Atan = atan_q30(STEP);

   always_comb begin
      cell_in_d = cell_in;
      for (int k = 0; k < 3; k++) begin
         if (!cell_in.lane[k].z[CordicWidth-1]) begin
            cell_in_d.lane[k].x = cell_in.lane[k].x - (cell_in.lane[k].y >>> STEP);
            cell_in_d.lane[k].y = cell_in.lane[k].y + (cell_in.lane[k].x >>> STEP);
            cell_in_d.lane[k].z = cell_in.lane[k].z - Atan;
         end else begin
            cell_in_d.lane[k].x = cell_in.lane[k].x + (cell_in.lane[k].y >>> STEP);
            cell_in_d.lane[k].y = cell_in.lane[k].y - (cell_in.lane[k].x >>> STEP);
            cell_in_d.lane[k].z = cell_in.lane[k].z + Atan;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cell_ff <= cell_in_d;
      end
   end

   assign cell_out = cell_ff;
endmodule

FILE: rtl/tarm_mix.sv
// Matrix product stages: products, sums, rounding and saturation.
// Depends on tarm_pkg.
module tarm_mix (
   input  logic                                         clock,
   input  logic                                         advance,
   input  logic signed [tarm_pkg::TrigWidth-1:0]        cos_in [3],
   input  logic signed [tarm_pkg::TrigWidth-1:0]        sin_in [3],
   output tarm_pkg::rsp_type                            rsp_out
);
   import tarm_pkg::*;

   localparam int PW = 2 * TrigWidth;
   localparam int SW = 3 * TrigWidth + 2;
   // pair products are split here so the second multiply stays narrow
   localparam int LoBits = TrigWidth - 1;

   // stage A: pair products, Q40
   logic signed [PW-1:0] c1c2_ff, s1c2_ff, c1c3_ff, s1c3_ff, c1s3_ff, s1s3_ff;
   logic signed [PW-1:0] c2c3_ff, c2s3_ff;
   logic signed [TrigWidth-1:0] s2_a_ff, s2_b_ff;
   // stage B: plain terms less low partial products, high partial products, Q60
   logic signed [SW-1:0] u_ff [9];
   logic signed [SW-1:0] t_ff [4];
   rsp_type rsp_ff;
   logic signed [PW-1:0] tri_src [4];
   logic signed [TrigWidth-1:0] tri_s2 [4];
   logic signed [PW:0] hi_prod [4];
   logic signed [PW-1:0] lo_prod [4];

   function automatic logic signed [EntryWidth-1:0] to_entry(input logic signed [SW:0] v);
      logic signed [SW:0] r;
      logic signed [SW-46:0] q;
      r = v + (SW+1)'(64'sd1 <<< 45);
      q = r[SW:46];
      if (q > (SW-45)'(EntryMax)) return EntryMax;
      if (q < -(SW-45)'(EntryMax)) return -EntryMax;
      return q[EntryWidth-1:0];
   endfunction

   // s2 times a pair product, as high and low halves
   always_comb begin
      tri_src[0] = c1s3_ff;
      tri_s2[0] = s2_a_ff;
      tri_src[1] = s1s3_ff;
      tri_s2[1] = s2_b_ff;
      tri_src[2] = c1c3_ff;
      tri_s2[2] = s2_a_ff;
      tri_src[3] = s1c3_ff;
      tri_s2[3] = s2_b_ff;
      for (int k = 0; k < 4; k++) begin
         hi_prod[k] = tri_s2[k] * $signed(tri_src[k][PW-1:LoBits]);
         lo_prod[k] = tri_s2[k] * $signed({1'b0, tri_src[k][LoBits-1:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1c2_ff <= cos_in[0] * cos_in[1];
         s1c2_ff <= sin_in[0] * cos_in[1];
         c1c3_ff <= cos_in[0] * cos_in[2];
         s1c3_ff <= sin_in[0] * cos_in[2];
         c1s3_ff <= cos_in[0] * sin_in[2];
         s1s3_ff <= sin_in[0] * sin_in[2];
         c2c3_ff <= cos_in[1] * cos_in[2];
         c2s3_ff <= sin_in[2] * cos_in[1];
         s2_a_ff <= sin_in[1];
         s2_b_ff <= sin_in[1];
         // second multiply; terms with "one" are shifts by 20 (by 40 for s2 alone)
         u_ff[0] <= SW'(c1c2_ff) <<< 20;
         u_ff[1] <= SW'(s1c2_ff) <<< 20;
         u_ff[2] <= SW'(s2_a_ff) <<< 40;
         u_ff[3] <= -(SW'(s1c3_ff) <<< 20) - SW'(lo_prod[0]);
         t_ff[0] <= SW'(hi_prod[0]);
         u_ff[4] <= (SW'(c1c3_ff) <<< 20) - SW'(lo_prod[1]);
         t_ff[1] <= SW'(hi_prod[1]);
         u_ff[5] <= SW'(c2s3_ff) <<< 20;
         u_ff[6] <= (SW'(s1s3_ff) <<< 20) - SW'(lo_prod[2]);
         t_ff[2] <= SW'(hi_prod[2]);
         u_ff[7] <= -(SW'(c1s3_ff) <<< 20) - SW'(lo_prod[3]);
         t_ff[3] <= SW'(hi_prod[3]);
         u_ff[8] <= SW'(c2c3_ff) <<< 20;
         rsp_ff.entry_r0_c0 <= to_entry((SW+1)'(u_ff[0]));
         rsp_ff.entry_r0_c1 <= to_entry((SW+1)'(u_ff[1]));
         rsp_ff.entry_r0_c2 <= to_entry((SW+1)'(u_ff[2]));
         rsp_ff.entry_r1_c0 <= to_entry((SW+1)'(u_ff[3]) - ((SW+1)'(t_ff[0]) <<< LoBits));
         rsp_ff.entry_r1_c1 <= to_entry((SW+1)'(u_ff[4]) - ((SW+1)'(t_ff[1]) <<< LoBits));
         rsp_ff.entry_r1_c2 <= to_entry((SW+1)'(u_ff[5]));
         rsp_ff.entry_r2_c0 <= to_entry((SW+1)'(u_ff[6]) - ((SW+1)'(t_ff[2]) <<< LoBits));
         rsp_ff.entry_r2_c1 <= to_entry((SW+1)'(u_ff[7]) - ((SW+1)'(t_ff[3]) <<< LoBits));
         rsp_ff.entry_r2_c2 <= to_entry((SW+1)'(u_ff[8]));
      end
   end

   assign rsp_out = rsp_ff;
endmodule

FILE: rtl/three_angle_rotation_matrix.sv
// Top level: angle reduction, CORDIC cell chain, matrix product, output register.
// Depends on tarm_pkg, tarm_cell, tarm_mix.
// Takes one angle triple per cycle while req_ready is high and gives the
// 3x3 rotation matrix U = R12 * R02 * R01 in Q2.14. At most 24 CORDIC cells
// are built. Registers in order: one for angle wrap and fold, one per CORDIC cell,
// one for the sign fix and Q20 rounding, two for the products, one for
// rounding and saturation, one for the output register. Items can follow
// back to back. The pipeline moves as a whole unless its last slot and the
// output register both hold an item and rsp_ready is low; only then does
// req_ready drop.
module three_angle_rotation_matrix #(
   parameter int TRIG_STAGES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tarm_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tarm_pkg::rsp_type   rsp_data
);
   import tarm_pkg::*;

   localparam int NCell = (TRIG_STAGES < AtanEntries) ? TRIG_STAGES : AtanEntries;
   localparam int Depth = NCell + 5;

   logic [Depth-1:0] valid_ff;
   logic advance;
   logic skid_valid_ff;
   rsp_type skid_ff, mix_rsp;
   cell_type chain [NCell+1];
   cell_type head_ff, head_in;
   logic signed [TrigWidth-1:0] cos_ff [3], sin_ff [3];

   assign advance = !valid_ff[Depth-1] || !skid_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      logic signed [AngleWidth-1:0] a [3];
      logic signed [CordicWidth-1:0] z;
      a[0] = req_data.angle_01;
      a[1] = req_data.angle_02;
      a[2] = req_data.angle_12;
      head_in = '0;
      for (int k = 0; k < 3; k++) begin
         z = CordicWidth'(a[k]) <<< 17;
         if (z > PiQ30) z = z - (PiQ30 <<< 1);
         else if (z < -PiQ30) z = z + (PiQ30 <<< 1);
         head_in.lane[k].flip = 1'b0;
         if (z > HalfPiQ30) begin
            z = z - PiQ30; head_in.lane[k].flip = 1'b1;
         end else if (z < -HalfPiQ30) begin
            z = z + PiQ30; head_in.lane[k].flip = 1'b1;
         end
         head_in.lane[k].x = InvGainQ30;
         head_in.lane[k].y = '0;
         head_in.lane[k].z = z;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) head_ff <= head_in;
   end
   assign chain[0] = head_ff;

   for (genvar g = 0; g < NCell; g++) begin : g_cell
      tarm_cell #(.STEP(g)) u_cell (
         .clock(clock), .advance(advance), .cell_in(chain[g]), .cell_out(chain[g+1])
      );
   end

   // sign fix and Q20 rounding
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            logic signed [CordicWidth-1:0] xs, ys;
            xs = chain[NCell].lane[k].flip ? -chain[NCell].lane[k].x : chain[NCell].lane[k].x;
            ys = chain[NCell].lane[k].flip ? -chain[NCell].lane[k].y : chain[NCell].lane[k].y;
            cos_ff[k] <= TrigWidth'((xs + 36'sd512) >>> 10);
            sin_ff[k] <= TrigWidth'((ys + 36'sd512) >>> 10);
         end
      end
   end

   tarm_mix u_mix (
      .clock(clock), .advance(advance), .cos_in(cos_ff), .sin_in(sin_ff), .rsp_out(mix_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (advance) valid_ff <= {valid_ff[Depth-2:0], req_valid};
         if (advance && valid_ff[Depth-1]) skid_valid_ff <= 1'b1;
         else if (rsp_ready) skid_valid_ff <= 1'b0;
      end
      if (advance && valid_ff[Depth-1]) skid_ff <= mix_rsp;
   end

   assign rsp_valid = skid_valid_ff;
   assign rsp_data = skid_ff;
endmodule

FILE: rtl/tarm_checker.sv
// Port-level checks for the rotation matrix block, bound to the top level.
// Depends on tarm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tarm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tarm_pkg::rsp_type rsp_data
);
   import tarm_pkg::*;
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped while stalled")
   `CHK_IMPL(a_sat, clock, reset, rsp_valid, rsp_data.entry_r0_c2 <= EntryMax && rsp_data.entry_r0_c2 >= -EntryMax, "entry out of range")
   `CHK_IMPL(a_ready, clock, reset, !rsp_valid, req_ready, "input stalled with empty output")
   `CHK_NEXT(a_reset, clock, 1'b0, reset, !rsp_valid, "result after reset")
endmodule

bind three_angle_rotation_matrix tarm_checker u_tarm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
